// ===== hw/rtl/akv_pkg.sv =====
// Shared types and constants for the associative key/value table.
// Field widths, action codes and the controller/datapath command and status words.
// No dependencies.
package akv_pkg;

  localparam int ACTION_W = 3;
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 4;
  localparam int PAIR_W   = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT   = 3'd0,
    ACT_UPDATE   = 3'd1,
    ACT_UPSERT   = 3'd2,
    ACT_ERASE    = 3'd3,
    ACT_LOOKUP   = 3'd4,
    ACT_READ_IDX = 3'd5
  } akv_action_t;

  typedef struct packed {
    logic start;   // capture the request and restart the slot scan
    logic issue;   // read the slot at the scan address and advance
    logic commit;  // apply the table change and load the result word
  } akv_cmd_t;

  typedef struct packed {
    logic scan_last;  // scan address points at the highest slot
  } akv_sts_t;

endpackage

// ===== hw/rtl/akv_in_if.sv =====
// Input channel of the associative key/value table: valid/ready plus one request word.
// Depends on akv_pkg for the field widths.
interface akv_in_if;
  import akv_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [KEY_W-1:0]    key;
  logic [VALUE_W-1:0]  value;
  logic [INDEX_W-1:0]  index;

  modport source (output valid, action, key, value, index, input ready);
  modport sink   (input valid, action, key, value, index, output ready);

endinterface

// ===== hw/rtl/akv_out_if.sv =====
// Result channel of the associative key/value table: valid/ready plus one result word.
// Depends on akv_pkg for the field widths.
interface akv_out_if;
  import akv_pkg::*;

  logic               valid;
  logic               ready;
  logic               ok;
  logic [KEY_W-1:0]   found_key;
  logic [VALUE_W-1:0] found_value;
  logic [PAIR_W-1:0]  pair_count;

  modport source (output valid, ok, found_key, found_value, pair_count, input ready);
  modport sink   (input valid, ok, found_key, found_value, pair_count, output ready);

endinterface

// ===== hw/rtl/associative_key_value_table.sv =====
// Associative key/value table, top level. An accepted input word is scanned against every
// slot and then committed into the result register; a new input word is taken only after
// that commit. The slot scan reads one slot of the key/value memories per cycle.
// A waiting result word is held in the output register until taken.
// Reset (synchronous, rst_n low) empties the table at once: valid bits and pair count clear.
// Depends on akv_pkg, akv_in_if, akv_out_if, akv_ctrl and akv_datapath.
module associative_key_value_table #(
  parameter int CAPACITY    = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input logic       clk,
  input logic       rst_n,
  akv_in_if.sink    in_item,
  akv_out_if.source out_item
);
  import akv_pkg::*;

  akv_cmd_t cmd;
  akv_sts_t sts;

  akv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_item.valid),
    .in_ready  (in_item.ready),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  akv_datapath #(
    .CAPACITY    (CAPACITY),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_item.action),
    .in_key          (in_item.key),
    .in_value        (in_item.value),
    .in_index        (in_item.index),
    .out_ok          (out_item.ok),
    .out_found_key   (out_item.found_key),
    .out_found_value (out_item.found_value),
    .out_pair_count  (out_item.pair_count)
  );

endmodule

// ===== hw/rtl/akv_ctrl.sv =====
// Controller state machine of the associative key/value table.
// Sequences accept, slot scan, drain and commit; owns the result valid flag.
// Depends on akv_pkg for the command and status words.
module akv_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output akv_pkg::akv_cmd_t cmd,
  input  akv_pkg::akv_sts_t sts
);
  import akv_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      // The last slot read is compared during this cycle.
      S_DRAIN: begin
        state_nxt = S_COMMIT;
      end
      // Hold the change until the previous result word has been taken.
      S_COMMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/akv_datapath.sv =====
// Datapath of the associative key/value table: slot memories, valid bits, pair count,
// scan compare and the result register. Commanded by akv_ctrl.
// Depends on akv_pkg for field widths, action codes and command/status words.
module akv_datapath #(
  parameter int CAPACITY    = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  akv_pkg::akv_cmd_t            cmd,
  output akv_pkg::akv_sts_t            sts,
  input  logic [akv_pkg::ACTION_W-1:0] in_action,
  input  logic [akv_pkg::KEY_W-1:0]    in_key,
  input  logic [akv_pkg::VALUE_W-1:0]  in_value,
  input  logic [akv_pkg::INDEX_W-1:0]  in_index,
  output logic                         out_ok,
  output logic [akv_pkg::KEY_W-1:0]    out_found_key,
  output logic [akv_pkg::VALUE_W-1:0]  out_found_value,
  output logic [akv_pkg::PAIR_W-1:0]   out_pair_count
);
  import akv_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);

  // Slot storage.
  logic [KEY_WIDTH-1:0]   key_mem   [CAPACITY];
  logic [VALUE_WIDTH-1:0] value_mem [CAPACITY];
  logic [CAPACITY-1:0]    slot_valid_r;
  logic [CW-1:0]          pair_cnt_r;

  // Captured request.
  akv_action_t            act_r;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [INDEX_W-1:0]     idx_r;

  // Scan pipeline.
  logic [AW-1:0]          scan_addr_r;
  logic [AW-1:0]          chk_addr_r;
  logic                   chk_vld_r;
  logic                   sv_r;
  logic [KEY_WIDTH-1:0]   rd_key_r;
  logic [VALUE_WIDTH-1:0] rd_val_r;

  // Scan findings.
  logic                   hit_found_r;
  logic [AW-1:0]          hit_addr_r;
  logic [VALUE_WIDTH-1:0] hit_val_r;
  logic                   empty_found_r;
  logic [AW-1:0]          empty_addr_r;
  logic                   ix_found_r;
  logic [KEY_WIDTH-1:0]   ix_key_r;
  logic [VALUE_WIDTH-1:0] ix_val_r;
  logic [CW-1:0]          seen_r;

  // Result register.
  logic                   ok_r;
  logic [KEY_W-1:0]       fkey_r;
  logic [VALUE_W-1:0]     fval_r;
  logic [PAIR_W-1:0]      pcnt_r;

  // Commit decode.
  logic                   wr_key_en;
  logic                   wr_val_en;
  logic                   set_v;
  logic                   clr_v;
  logic [AW-1:0]          wr_addr;
  logic                   ok_c;
  logic [KEY_WIDTH-1:0]   fk_c;
  logic [VALUE_WIDTH-1:0] fv_c;
  logic [CW-1:0]          cnt_nxt;

  logic                   key_match;
  logic                   idx_match;

  assign key_match     = (rd_key_r == key_r);
  assign idx_match     = (SW'(seen_r) == SW'(idx_r));
  assign sts.scan_last = (scan_addr_r == LAST_ADDR);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      act_r <= akv_action_t'(in_action);
      key_r <= KEY_WIDTH'(in_key);
      val_r <= VALUE_WIDTH'(in_value);
      idx_r <= in_index;
    end
  end

  // One slot is read per cycle; the read word is registered and compared next cycle.
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_key_en) begin
      key_mem[wr_addr] <= key_r;
    end
    if (cmd.commit && wr_val_en) begin
      value_mem[wr_addr] <= val_r;
    end
    rd_key_r   <= key_mem[scan_addr_r];
    rd_val_r   <= value_mem[scan_addr_r];
    sv_r       <= slot_valid_r[scan_addr_r];
    chk_addr_r <= scan_addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_addr_r <= '0;
      chk_vld_r   <= 1'b0;
    end else begin
      chk_vld_r <= cmd.issue;
      if (cmd.start) begin
        scan_addr_r <= '0;
      end else if (cmd.issue && !sts.scan_last) begin
        scan_addr_r <= scan_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_found_r   <= 1'b0;
      empty_found_r <= 1'b0;
      ix_found_r    <= 1'b0;
      seen_r        <= '0;
    end else if (cmd.start) begin
      hit_found_r   <= 1'b0;
      empty_found_r <= 1'b0;
      ix_found_r    <= 1'b0;
      seen_r        <= '0;
    end else if (chk_vld_r) begin
      if (sv_r) begin
        if (!hit_found_r && key_match) begin
          hit_found_r <= 1'b1;
        end
        if (!ix_found_r && idx_match) begin
          ix_found_r <= 1'b1;
        end
        seen_r <= seen_r + 1'b1;
      end else if (!empty_found_r) begin
        empty_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chk_vld_r) begin
      if (sv_r) begin
        if (!hit_found_r && key_match) begin
          hit_addr_r <= chk_addr_r;
          hit_val_r  <= rd_val_r;
        end
        if (!ix_found_r && idx_match) begin
          ix_key_r <= rd_key_r;
          ix_val_r <= rd_val_r;
        end
      end else if (!empty_found_r) begin
        empty_addr_r <= chk_addr_r;
      end
    end
  end

  always_comb begin
    wr_key_en = 1'b0;
    wr_val_en = 1'b0;
    set_v     = 1'b0;
    clr_v     = 1'b0;
    wr_addr   = hit_addr_r;
    ok_c      = 1'b0;
    fk_c      = '0;
    fv_c      = '0;
    cnt_nxt   = pair_cnt_r;
    case (act_r)
      ACT_INSERT, ACT_UPSERT: begin
        if (hit_found_r) begin
          if (act_r == ACT_UPSERT) begin
            wr_val_en = 1'b1;
            ok_c      = 1'b1;
          end
        end else if (empty_found_r) begin
          wr_addr   = empty_addr_r;
          wr_key_en = 1'b1;
          wr_val_en = 1'b1;
          set_v     = 1'b1;
          ok_c      = 1'b1;
          cnt_nxt   = pair_cnt_r + 1'b1;
        end
      end
      ACT_UPDATE: begin
        if (hit_found_r) begin
          wr_val_en = 1'b1;
          ok_c      = 1'b1;
        end
      end
      ACT_ERASE: begin
        if (hit_found_r) begin
          clr_v   = 1'b1;
          ok_c    = 1'b1;
          cnt_nxt = pair_cnt_r - 1'b1;
        end
      end
      ACT_LOOKUP: begin
        if (hit_found_r) begin
          ok_c = 1'b1;
          fv_c = hit_val_r;
        end
      end
      ACT_READ_IDX: begin
        if (ix_found_r) begin
          ok_c = 1'b1;
          fk_c = ix_key_r;
          fv_c = ix_val_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      pair_cnt_r   <= '0;
    end else if (cmd.commit) begin
      if (set_v) begin
        slot_valid_r[wr_addr] <= 1'b1;
      end
      if (clr_v) begin
        slot_valid_r[wr_addr] <= 1'b0;
      end
      pair_cnt_r <= cnt_nxt;
    end
  end

  // The pair count wraps to the field width when the table holds more.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ok_r   <= ok_c;
      fkey_r <= KEY_W'(fk_c);
      fval_r <= VALUE_W'(fv_c);
      pcnt_r <= PAIR_W'(cnt_nxt);
    end
  end

  assign out_ok          = ok_r;
  assign out_found_key   = fkey_r;
  assign out_found_value = fval_r;
  assign out_pair_count  = pcnt_r;

endmodule

// ===== tb/sv/associative_key_value_table_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the associative key/value table: random and directed table actions.
// Depends on akv_pkg, akv_in_if, akv_out_if and the associative_key_value_table RTL.
module associative_key_value_table_test;
  import akv_pkg::*;

  localparam int SLOTS     = 16;
  localparam int MAX_CYCLE = 300000;
  localparam int TAIL_WAIT = 40;

  // Action codes that the package leaves without a name.
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  localparam int PHASE_FILL  = 0;
  localparam int PHASE_MIXED = 1;
  localparam int PHASE_DRAIN = 2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [KEY_W-1:0]    key;
    logic [VALUE_W-1:0]  value;
    logic [INDEX_W-1:0]  index;
  } table_req_t;

  typedef struct packed {
    logic               ok;
    logic [KEY_W-1:0]   found_key;
    logic [VALUE_W-1:0] found_value;
    logic [PAIR_W-1:0]  pair_count;
  } table_result_t;

  logic clk;
  logic rst_n;

  akv_in_if  in_item ();
  akv_out_if out_item ();

  associative_key_value_table dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .out_item (out_item)
  );

  // Shadow copy of the table.
  logic               shadow_valid [SLOTS];
  logic [KEY_W-1:0]   shadow_key   [SLOTS];
  logic [VALUE_W-1:0] shadow_value [SLOTS];

  table_req_t    request_backlog [$];
  table_result_t results_due     [$];
  table_req_t    word_on_bus;

  int  total_requests;
  int  accepted_count;
  int  sent_count;
  int  checked_count;
  int  mismatches;
  int  cycle_count;
  int  in_gap;
  int  out_stall;
  bit  calm;

  // Applies one action to the shadow table and returns the result word it yields.
  function automatic table_result_t table_apply(table_req_t req);
    table_result_t res;
    int hit;
    int empty;
    int seen;
    int occupied;
    res = '0;
    hit = -1;
    empty = -1;
    seen = 0;
    occupied = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_valid[i] && shadow_key[i] == req.key && hit < 0) hit = i;
      if (!shadow_valid[i] && empty < 0) empty = i;
    end
    case (req.action)
      ACT_INSERT, ACT_UPSERT: begin
        if (hit >= 0) begin
          if (req.action == ACT_UPSERT) begin
            shadow_value[hit] = req.value;
            res.ok = 1'b1;
          end
        end else if (empty >= 0) begin
          shadow_key[empty]   = req.key;
          shadow_value[empty] = req.value;
          shadow_valid[empty] = 1'b1;
          res.ok = 1'b1;
        end
      end
      ACT_UPDATE: begin
        if (hit >= 0) begin
          shadow_value[hit] = req.value;
          res.ok = 1'b1;
        end
      end
      ACT_ERASE: begin
        if (hit >= 0) begin
          shadow_valid[hit] = 1'b0;
          res.ok = 1'b1;
        end
      end
      ACT_LOOKUP: begin
        if (hit >= 0) begin
          res.found_value = shadow_value[hit];
          res.ok = 1'b1;
        end
      end
      ACT_READ_IDX: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (shadow_valid[i]) begin
            if (seen == req.index && !res.ok) begin
              res.found_key   = shadow_key[i];
              res.found_value = shadow_value[i];
              res.ok = 1'b1;
            end
            seen++;
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < SLOTS; i++) if (shadow_valid[i]) occupied++;
    res.pair_count = occupied[PAIR_W-1:0];
    return res;
  endfunction

  task automatic queue_request(logic [ACTION_W-1:0] action, logic [KEY_W-1:0] key,
                               logic [VALUE_W-1:0] value, logic [INDEX_W-1:0] index);
    table_req_t req;
    req.action = action;
    req.key    = key;
    req.value  = value;
    req.index  = index;
    request_backlog.push_back(req);
  endtask

  task automatic note_mismatch(string what);
    $display("mismatch on result word %0d: %s", checked_count, what);
    mismatches++;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLE) begin
      $display("associative_key_value_table regression: fail");
      $finish;
    end
  end

  // Request driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_item.valid <= 1'b0;
      in_gap <= 0;
      calm <= 1'b0;
    end else begin
      if (in_item.valid && in_item.ready) begin
        results_due.push_back(table_apply(word_on_bus));
        accepted_count++;
      end
      calm <= (request_backlog.size() < 120) || ((sent_count / 50) % 4 == 3);
      if (!in_item.valid || in_item.ready) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          in_item.valid <= 1'b0;
        end else if (request_backlog.size() != 0 && !calm && $urandom_range(0, 5) == 0) begin
          in_gap <= $urandom_range(1, 17) - 1;
          in_item.valid <= 1'b0;
        end else if (request_backlog.size() != 0) begin
          word_on_bus = request_backlog.pop_front();
          sent_count++;
          in_item.action <= word_on_bus.action;
          in_item.key    <= word_on_bus.key;
          in_item.value  <= word_on_bus.value;
          in_item.index  <= word_on_bus.index;
          in_item.valid  <= 1'b1;
        end else begin
          in_item.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_item.ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_item.valid && out_item.ready) begin
        if (results_due.size() == 0) begin
          note_mismatch("result word arrived with nothing outstanding");
        end else begin
          table_result_t want;
          want = results_due.pop_front();
          if (out_item.ok !== want.ok)
            note_mismatch($sformatf("ok got %b want %b", out_item.ok, want.ok));
          if (out_item.found_key !== want.found_key)
            note_mismatch($sformatf("found_key got %h want %h",
                                    out_item.found_key, want.found_key));
          if (out_item.found_value !== want.found_value)
            note_mismatch($sformatf("found_value got %h want %h",
                                    out_item.found_value, want.found_value));
          if (out_item.pair_count !== want.pair_count)
            note_mismatch($sformatf("pair_count got %0d want %0d",
                                    out_item.pair_count, want.pair_count));
        end
        checked_count++;
      end
      if (out_stall != 0) begin
        out_stall <= out_stall - 1;
        out_item.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        out_stall <= $urandom_range(1, 17) - 1;
        out_item.ready <= 1'b0;
      end else begin
        out_item.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [KEY_W-1:0]    key_pool [20];
    logic [ACTION_W-1:0] action;
    logic [KEY_W-1:0]    key;
    int phase_kind;
    int phase_len;
    int pick;

    rst_n = 1'b0;
    in_item.valid  = 1'b0;
    in_item.action = '0;
    in_item.key    = '0;
    in_item.value  = '0;
    in_item.index  = '0;
    out_item.ready = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i]   = '0;
      shadow_value[i] = '0;
    end

    // Misses on the empty table, the spare action codes, then the basic actions.
    queue_request(ACT_LOOKUP,   32'h0,        32'h0,        4'd0);
    queue_request(ACT_READ_IDX, 32'h0,        32'h0,        4'd0);
    queue_request(ACT_ERASE,    32'hffffffff, 32'h0,        4'd0);
    queue_request(ACT_UPDATE,   32'h0,        32'hffffffff, 4'd0);
    queue_request(ACT_SPARE_LO, 32'h0,        32'h0,        4'd0);
    queue_request(ACT_SPARE_HI, 32'hffffffff, 32'hffffffff, 4'd15);
    queue_request(ACT_INSERT,   32'h0,        32'hffffffff, 4'd0);
    queue_request(ACT_INSERT,   32'hffffffff, 32'h0,        4'd0);
    queue_request(ACT_INSERT,   32'h0,        32'h1,        4'd0);
    queue_request(ACT_UPSERT,   32'h0,        32'h12345678, 4'd0);
    queue_request(ACT_UPSERT,   32'h80000001, 32'ha5a5a5a5, 4'd0);
    queue_request(ACT_UPDATE,   32'hffffffff, 32'hffffffff, 4'd0);
    queue_request(ACT_SPARE_LO, 32'h0,        32'h0,        4'd0);
    queue_request(ACT_LOOKUP,   32'h0,        32'h0,        4'd0);
    queue_request(ACT_LOOKUP,   32'hffffffff, 32'h0,        4'd0);
    queue_request(ACT_READ_IDX, 32'h0,        32'h0,        4'd0);
    queue_request(ACT_READ_IDX, 32'h0,        32'h0,        4'd2);
    queue_request(ACT_READ_IDX, 32'h0,        32'h0,        4'd3);
    queue_request(ACT_READ_IDX, 32'h0,        32'h0,        4'd15);
    queue_request(ACT_ERASE,    32'h0,        32'h0,        4'd0);
    queue_request(ACT_LOOKUP,   32'h0,        32'h0,        4'd0);
    // The freed lowest slot must take the next new key.
    queue_request(ACT_INSERT,   32'h5,        32'h5,        4'd0);
    queue_request(ACT_READ_IDX, 32'h0,        32'h0,        4'd0);
    queue_request(ACT_ERASE,    32'h80000001, 32'h0,        4'd0);

    // Random phases over a small key set, so the table fills, churns and drains.
    while (request_backlog.size() < 854) begin
      phase_kind = $urandom_range(PHASE_FILL, PHASE_DRAIN);
      phase_len  = $urandom_range(40, 80);
      foreach (key_pool[i]) key_pool[i] = $urandom;
      if ($urandom_range(0, 1) == 0) key_pool[0] = '0;
      if ($urandom_range(0, 1) == 0) key_pool[1] = '1;
      for (int n = 0; n < phase_len; n++) begin
        pick = $urandom_range(0, 9);
        key  = key_pool[$urandom_range(0, 19)];
        case (phase_kind)
          PHASE_FILL:
            action = (pick < 5) ? ACT_INSERT : (pick < 7) ? ACT_UPSERT :
                     (pick == 7) ? ACT_LOOKUP : (pick == 8) ? ACT_READ_IDX : ACT_UPDATE;
          PHASE_DRAIN:
            action = (pick < 4) ? ACT_ERASE : (pick == 4) ? ACT_LOOKUP :
                     (pick == 6) ? ACT_UPDATE : (pick == 7) ? ACT_UPSERT :
                     (pick == 8) ? ACT_INSERT : ACT_READ_IDX;
          default:
            action = ACTION_W'($urandom_range(ACT_INSERT, ACT_READ_IDX));
        endcase
        // A share of noise: any code, keys that are almost surely absent.
        if ($urandom_range(0, 11) == 0) begin
          action = ACTION_W'($urandom_range(0, 7));
          key    = $urandom;
        end
        queue_request(action, key, $urandom, INDEX_W'($urandom_range(0, 15)));
      end
    end
    total_requests = request_backlog.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_count < total_requests) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (results_due.size() != 0) note_mismatch("results still outstanding at the end");

    if (mismatches == 0) begin
      $display("associative_key_value_table regression: pass");
    end else begin
      $display("associative_key_value_table regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/akv_pkg.sv
hw/rtl/akv_in_if.sv
hw/rtl/akv_out_if.sv
hw/rtl/akv_ctrl.sv
hw/rtl/akv_datapath.sv
hw/rtl/associative_key_value_table.sv
tb/sv/associative_key_value_table_test.sv
